FILE: rtl/core/red_blob_centroid_pd_tracker_core_defines.svh
// assertion macros for the red blob centroid tracker core
// included by the top level; no other dependencies
`ifndef RED_BLOB_CENTROID_PD_TRACKER_CORE_DEFINES_SVH
`define RED_BLOB_CENTROID_PD_TRACKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbc assertion failed");
`define RBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbc assertion failed");
`else
`define RBC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/rbc_pkg.sv
// shared widths, register indexes, types and saturation helpers
// for the red blob centroid tracker core; no dependencies
package rbc_pkg;

    localparam int MAX_DIM    = 2048;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = 12;
    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 34;
    localparam int CNT_W      = 23;
    localparam int ERR_W      = 12;
    localparam int DRV_W      = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN      = 2'd3;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 12'd320;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 12'd240;
    localparam logic [GAIN_W-1:0] RST_KP_GAIN      = 16'd819;
    localparam logic [GAIN_W-1:0] RST_KD_GAIN      = 16'd0;

    typedef struct packed {
        logic             frame_end;
        logic [SUM_W-1:0] sum_col;
        logic [SUM_W-1:0] sum_row;
        logic [CNT_W-1:0] red_count;
    } t_acc_stat;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (32'(d) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic signed [ERR_W-1:0] sat_err(input logic [SUM_W-1:0] q,
                                                        input logic [DIM_W-2:0] half);
        logic signed [SUM_W:0] d;
        logic signed [ERR_W-1:0] r;
        d = $signed({1'b0, q}) - $signed((SUM_W+1)'(half));
        if (d > $signed((SUM_W+1)'(2047))) begin
            r = 12'sd2047;
        end else if (d < -$signed((SUM_W+1)'(2048))) begin
            r = -12'sd2048;
        end else begin
            r = d[ERR_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DRV_W-1:0] sat_drive(input logic signed [DRV_W:0] a);
        logic signed [DRV_W-1:0] r;
        if (a > $signed({2'b00, {(DRV_W-1){1'b1}}})) begin
            r = {1'b0, {(DRV_W-1){1'b1}}};
        end else if (a < $signed({2'b11, {(DRV_W-1){1'b0}}})) begin
            r = {1'b1, {(DRV_W-1){1'b0}}};
        end else begin
            r = a[DRV_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/rbc_accum.sv
// pixel classification, coordinate sums, red pixel count and position counters
// depends on rbc_pkg
module rbc_accum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_beat,
    input  logic                       i_clear,
    input  logic [rbc_pkg::PIX_W-1:0]  i_red,
    input  logic [rbc_pkg::PIX_W-1:0]  i_green,
    input  logic [rbc_pkg::PIX_W-1:0]  i_blue,
    input  logic [rbc_pkg::DIM_W-1:0]  i_width,
    input  logic [rbc_pkg::DIM_W-1:0]  i_height,
    output rbc_pkg::t_acc_stat         o_stat
);
    import rbc_pkg::*;

    logic [SUM_W-1:0] r_sum_col, r_sum_row;
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_col, r_row;
    logic             w_is_red, w_col_end, w_frame_end;

    assign w_is_red    = ({1'b0, i_red} > {i_green, 1'b0}) && ({1'b0, i_red} > {i_blue, 1'b0});
    assign w_col_end   = (DIM_W'(r_row) + DIM_W'(1)) >= i_height;
    assign w_frame_end = w_col_end && ((DIM_W'(r_col) + DIM_W'(1)) >= i_width);

    assign o_stat.frame_end = w_frame_end;
    assign o_stat.sum_col   = r_sum_col;
    assign o_stat.sum_row   = r_sum_row;
    assign o_stat.red_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_col <= '0;
            r_sum_row <= '0;
            r_count   <= '0;
            r_col     <= '0;
            r_row     <= '0;
        end else if (i_clear) begin
            r_sum_col <= '0;
            r_sum_row <= '0;
            r_count   <= '0;
        end else if (i_beat) begin
            if (w_is_red) begin
                r_sum_col <= r_sum_col + SUM_W'(r_col);
                r_sum_row <= r_sum_row + SUM_W'(r_row);
                r_count   <= r_count + CNT_W'(1);
            end
            if (w_frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_col_end) begin
                r_col <= r_col + POS_W'(1);
                r_row <= '0;
            end else begin
                r_row <= r_row + POS_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/rbc_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on rbc_pkg
module rbc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbc_pkg::SUM_W-1:0]  i_dividend,
    input  logic [rbc_pkg::CNT_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rbc_pkg::SUM_W-1:0]  o_quot
);
    import rbc_pkg::*;

    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_q;
    logic [CNT_W-1:0]     r_rem, r_div;
    logic [CNT_W:0]       w_trial;
    logic                 w_fits;

    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign o_done  = r_done;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_q <= {r_q[SUM_W-2:0], w_fits};
                if (w_fits) begin
                    r_rem <= CNT_W'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[CNT_W-1:0];
                end
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/rbc_pd.sv
// shared pd unit: one multiplier used for the proportional and derivative terms
// depends on rbc_pkg
module rbc_pd (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [rbc_pkg::ERR_W-1:0]  i_err,
    input  logic signed [rbc_pkg::ERR_W-1:0]  i_prev,
    input  logic [rbc_pkg::GAIN_W-1:0]        i_kp,
    input  logic [rbc_pkg::GAIN_W-1:0]        i_kd,
    output logic                              o_done,
    output logic signed [rbc_pkg::DRV_W-1:0]  o_drive
);
    import rbc_pkg::*;

    logic                     r_busy, r_done;
    logic [1:0]               r_step;
    logic signed [ERR_W:0]    r_b0, r_b1;
    logic signed [DRV_W-1:0]  r_prod, r_drive;
    logic signed [DRV_W:0]    r_acc;
    logic signed [GAIN_W:0]   w_mul_a;
    logic signed [ERR_W:0]    w_mul_b;
    logic signed [DRV_W-1:0]  w_prod;

    assign w_mul_a = (r_step == 2'd0) ? $signed({1'b0, i_kp}) : $signed({1'b0, i_kd});
    assign w_mul_b = (r_step == 2'd0) ? r_b0 : r_b1;
    assign w_prod  = w_mul_a * w_mul_b;
    assign o_done  = r_done;
    assign o_drive = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_b0   <= (ERR_W+1)'(i_err);
                r_b1   <= (ERR_W+1)'(i_prev) - (ERR_W+1)'(i_err);
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                case (r_step)
                    2'd0: begin
                        r_prod <= w_prod;
                    end
                    2'd1: begin
                        r_prod <= w_prod;
                        r_acc  <= (DRV_W+1)'(r_prod);
                    end
                    2'd2: begin
                        r_acc <= r_acc + (DRV_W+1)'(r_prod);
                    end
                    default: begin
                        r_drive <= sat_drive(r_acc);
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/core/red_blob_centroid_pd_tracker_core.sv
// red blob centroid tracker with pd drive: config registers, sequencer, output register
// depends on rbc_pkg, rbc_accum, rbc_div, rbc_pd and the core defines header
// after the last pixel beat of a frame, its result beat is computed by two 34-step divides
// and two 4-step pd passes on one multiplier; a frame with no red pixel skips both
// throughput: one pixel per cycle within a frame; input stalled until the result is registered
// reset: synchronous active low, restores register defaults, clears sums, counters and last errors
`include "red_blob_centroid_pd_tracker_core_defines.svh"

module red_blob_centroid_pd_tracker_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [rbc_pkg::PIX_W-1:0]             i_red,
    input  logic [rbc_pkg::PIX_W-1:0]             i_green,
    input  logic [rbc_pkg::PIX_W-1:0]             i_blue,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [rbc_pkg::ERR_W-1:0]      o_err_x,
    output logic signed [rbc_pkg::ERR_W-1:0]      o_err_y,
    output logic signed [rbc_pkg::DRV_W-1:0]      o_drive_x,
    output logic signed [rbc_pkg::DRV_W-1:0]      o_drive_y,
    output logic                                  o_found,
    input  logic                                  i_cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [rbc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import rbc_pkg::*;

    typedef enum logic [2:0] {
        S_PIX, S_CHK, S_DVX, S_DVY, S_PDX, S_PDY, S_OUT
    } t_state;

    t_state                  r_state;
    logic [DIM_W-1:0]        r_width, r_height;
    logic [GAIN_W-1:0]       r_kp, r_kd;
    logic signed [ERR_W-1:0] r_prev_x, r_prev_y;
    logic signed [ERR_W-1:0] r_res_err_x, r_res_err_y;
    logic signed [DRV_W-1:0] r_res_drv_x, r_res_drv_y;
    logic                    r_res_found;
    logic                    r_out_valid, r_found;
    logic signed [ERR_W-1:0] r_err_x, r_err_y;
    logic signed [DRV_W-1:0] r_drv_x, r_drv_y;

    logic [DIM_W-1:0]        w_eff_w, w_eff_h;
    logic                    w_beat, w_load, w_empty;
    t_acc_stat               w_stat;
    logic                    w_div_start, w_div_done;
    logic [SUM_W-1:0]        w_dividend, w_quot;
    logic                    w_pd_start, w_pd_done;
    logic signed [ERR_W-1:0] w_pd_err, w_pd_prev;
    logic signed [DRV_W-1:0] w_pd_drive;

    assign w_eff_w = eff_dim(r_width);
    assign w_eff_h = eff_dim(r_height);

    assign o_in_stall = (r_state != S_PIX);
    assign w_beat     = i_in_valid && !o_in_stall;
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign w_empty    = (w_stat.red_count == '0);

    assign w_div_start = ((r_state == S_CHK) && !w_empty) || ((r_state == S_DVX) && w_div_done);
    assign w_dividend  = (r_state == S_CHK) ? w_stat.sum_col : w_stat.sum_row;

    assign w_pd_start = ((r_state == S_DVY) && w_div_done) || ((r_state == S_PDX) && w_pd_done);
    assign w_pd_err   = (r_state == S_DVY) ? r_res_err_x : r_res_err_y;
    assign w_pd_prev  = (r_state == S_DVY) ? r_prev_x : r_prev_y;

    rbc_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_beat),
        .i_clear  (w_load),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_width  (w_eff_w),
        .i_height (w_eff_h),
        .o_stat   (w_stat)
    );

    rbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_stat.red_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    rbc_pd u_pd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_pd_start),
        .i_err   (w_pd_err),
        .i_prev  (w_pd_prev),
        .i_kp    (r_kp),
        .i_kd    (r_kd),
        .o_done  (w_pd_done),
        .o_drive (w_pd_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PIX;
            r_width     <= RST_FRAME_WIDTH;
            r_height    <= RST_FRAME_HEIGHT;
            r_kp        <= RST_KP_GAIN;
            r_kd        <= RST_KD_GAIN;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_width  <= i_cfg_wdata[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: r_height <= i_cfg_wdata[DIM_W-1:0];
                    CFG_KP_GAIN:      r_kp     <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_KD_GAIN:      r_kd     <= i_cfg_wdata[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_PIX: begin
                    if (w_beat && w_stat.frame_end) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (w_empty) begin
                        r_res_found <= 1'b0;
                        r_res_err_x <= '0;
                        r_res_err_y <= '0;
                        r_res_drv_x <= '0;
                        r_res_drv_y <= '0;
                        r_state     <= S_OUT;
                    end else begin
                        r_res_found <= 1'b1;
                        r_state     <= S_DVX;
                    end
                end
                S_DVX: begin
                    if (w_div_done) begin
                        r_res_err_x <= sat_err(w_quot, w_eff_w[DIM_W-1:1]);
                        r_state     <= S_DVY;
                    end
                end
                S_DVY: begin
                    if (w_div_done) begin
                        r_res_err_y <= sat_err(w_quot, w_eff_h[DIM_W-1:1]);
                        r_state     <= S_PDX;
                    end
                end
                S_PDX: begin
                    if (w_pd_done) begin
                        r_res_drv_x <= w_pd_drive;
                        r_state     <= S_PDY;
                    end
                end
                S_PDY: begin
                    if (w_pd_done) begin
                        r_res_drv_y <= w_pd_drive;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_found <= r_res_found;
                        r_err_x <= r_res_err_x;
                        r_err_y <= r_res_err_y;
                        r_drv_x <= r_res_drv_x;
                        r_drv_y <= r_res_drv_y;
                        if (r_res_found) begin
                            r_prev_x <= r_res_err_x;
                            r_prev_y <= r_res_err_y;
                        end
                        r_state <= S_PIX;
                    end
                end
                default: begin
                    r_state <= S_PIX;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_err_x     = r_err_x;
    assign o_err_y     = r_err_y;
    assign o_drive_x   = r_drv_x;
    assign o_drive_y   = r_drv_y;

    // empty frame beat carries zeros
    `RBC_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_err_x == '0 && o_err_y == '0 && o_drive_x == '0 && o_drive_y == '0)
    // divider finishes only while the sequencer waits for it
    `RBC_ASSERT_SAME(a_div_owner, i_clk, i_rst_n, w_div_done, r_state == S_DVX || r_state == S_DVY)
    // pd unit finishes only while the sequencer waits for it
    `RBC_ASSERT_SAME(a_pd_owner, i_clk, i_rst_n, w_pd_done, r_state == S_PDX || r_state == S_PDY)
    // a result load presents a beat and reopens the pixel input
    `RBC_ASSERT_NEXT(a_load_out, i_clk, i_rst_n, w_load, o_out_valid && !o_in_stall)

endmodule
